// File: rtl/periodic_task_dispatcher_top_assert.svh
// Assertion macros used by the dispatcher checker.
`ifndef PERIODIC_TASK_DISPATCHER_TOP_ASSERT_SVH
`define PERIODIC_TASK_DISPATCHER_TOP_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define PTD_CHECK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: check failed");

// Condition in one cycle that requires a consequence in the next.
`define PTD_CHECK_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("%m: check failed");

`endif

// File: rtl/ptd_pkg.sv
`timescale 1ns / 1ps

package ptd_pkg;

  // Table size and derived widths.
  localparam int SLOTS    = 16;
  localparam int MAX_OUT  = 16;
  localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TALLY_W  = $clog2(SLOTS + 1);
  localparam int CNT_W    = $clog2(MAX_OUT + 1);
  localparam int LIVE_MAX = (SLOTS > 31) ? 31 : SLOTS;

  // Request operation codes.
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // Slot states.
  localparam logic [1:0] ST_EMPTY  = 2'd0;
  localparam logic [1:0] ST_READY  = 2'd1;
  localparam logic [1:0] ST_ZOMBIE = 2'd2;

  // Result status codes.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_NOKEY = 2'd2;

  // Slot table write commands.
  localparam logic [2:0] TC_NONE = 3'd0;
  localparam logic [2:0] TC_FREE = 3'd1;
  localparam logic [2:0] TC_ADD  = 3'd2;
  localparam logic [2:0] TC_RUN  = 3'd3;
  localparam logic [2:0] TC_KILL = 3'd4;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] task_key;
    logic [31:0] run_period;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        due;
    logic [3:0]  slot_index;
    logic [15:0] due_key;
    logic [31:0] runs_done;
    logic [31:0] tick_now;
    logic [4:0]  live_tasks;
    logic        last;
  } rsp_t;

  // Write command from the sequencer to the slot table.
  typedef struct packed {
    logic [2:0]       code;
    logic [IDX_W-1:0] idx;
    logic [15:0]      key;
    logic [31:0]      period;
    logic [31:0]      tick;
  } tbl_cmd_t;

  // Contents of the slot under the scan pointer.
  typedef struct packed {
    logic [1:0]  state;
    logic [15:0] key;
    logic [31:0] period;
    logic [31:0] prev_tick;
    logic [31:0] runs;
  } slot_view_t;

  // Task count as reported, saturated at 31.
  function automatic logic [4:0] live_count(input logic [TALLY_W-1:0] t);
    logic [TALLY_W+4:0] w;
    w = {5'b0, t};
    if (w > (TALLY_W + 5)'(31)) begin
      return 5'd31;
    end
    return w[4:0];
  endfunction

  // Low four bits of a slot number.
  function automatic logic [3:0] slot_num(input logic [IDX_W-1:0] i);
    logic [IDX_W+3:0] w;
    w = {4'b0, i};
    return w[3:0];
  endfunction

endpackage

// File: rtl/ptd_slot_table.sv
`timescale 1ns / 1ps

module ptd_slot_table (
  input  logic               clk,
  input  logic               rst,
  input  ptd_pkg::tbl_cmd_t  cmd,
  input  logic [ptd_pkg::IDX_W-1:0] rd_idx,
  output ptd_pkg::slot_view_t view
);
  import ptd_pkg::*;

  logic [1:0]  slot_state     [SLOTS];
  logic [15:0] slot_key       [SLOTS];
  logic [31:0] slot_period    [SLOTS];
  logic [31:0] slot_prev_tick [SLOTS];
  logic [31:0] slot_runs      [SLOTS];

  // Slot states reset to empty; a tick frees every zombie at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_state[i] <= ST_EMPTY;
      end
    end else begin
      case (cmd.code)
        TC_FREE: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_state[i] == ST_ZOMBIE) begin
              slot_state[i] <= ST_EMPTY;
            end
          end
        end
        TC_ADD:  slot_state[cmd.idx] <= ST_READY;
        TC_KILL: slot_state[cmd.idx] <= ST_ZOMBIE;
        default: ;
      endcase
    end
  end

  // Task contents are written on add and on each run.
  always_ff @(posedge clk) begin
    case (cmd.code)
      TC_ADD: begin
        slot_key[cmd.idx]       <= cmd.key;
        slot_period[cmd.idx]    <= cmd.period;
        slot_prev_tick[cmd.idx] <= 32'd0;
        slot_runs[cmd.idx]      <= 32'd0;
      end
      TC_RUN: begin
        slot_prev_tick[cmd.idx] <= cmd.tick;
        slot_runs[cmd.idx]      <= slot_runs[cmd.idx] + 32'd1;
      end
      default: ;
    endcase
  end

  // One slot is visible at a time, under the scan pointer.
  assign view.state     = slot_state[rd_idx];
  assign view.key       = slot_key[rd_idx];
  assign view.period    = slot_period[rd_idx];
  assign view.prev_tick = slot_prev_tick[rd_idx];
  assign view.runs      = slot_runs[rd_idx];

endmodule

// File: rtl/ptd_due_unit.sv
`timescale 1ns / 1ps

module ptd_due_unit (
  input  logic [31:0] tick,
  input  logic [31:0] prev_tick,
  input  logic [31:0] period,
  output logic        due
);
  import ptd_pkg::*;

  logic [31:0] elapsed;

  // Elapsed ticks wrap modulo 2^32; a zero period runs on every tick.
  assign elapsed = tick - prev_tick;
  assign due     = (period == 32'd0) || (elapsed >= period);

endmodule

// File: rtl/ptd_ctrl.sv
`timescale 1ns / 1ps

module ptd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  ptd_pkg::req_t       req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output ptd_pkg::rsp_t       rsp,
  output ptd_pkg::tbl_cmd_t   cmd,
  output logic [ptd_pkg::IDX_W-1:0] rd_idx,
  input  ptd_pkg::slot_view_t view
);
  import ptd_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]         fsm;
  logic [1:0]         op_q;
  logic [15:0]        key_q;
  logic [31:0]        period_q;
  logic [IDX_W-1:0]   idx;
  logic [31:0]        tick_counter;
  logic [TALLY_W-1:0] tally;
  logic [CNT_W-1:0]   dcnt;
  logic               found;
  logic [IDX_W-1:0]   found_idx;
  logic               pend_valid;
  rsp_t               pend;

  logic accept;
  logic out_free;
  logic due;
  logic tick_hit;
  logic add_hit;
  logic rem_hit;
  logic last_idx;
  logic tick_stall;
  logic advance;
  logic rsp_load;
  rsp_t rsp_next;
  rsp_t final_rsp;
  rsp_t run_rsp;

  function automatic rsp_t mk_rsp(input logic [1:0] status, input logic is_due,
                                  input logic [3:0] slot, input logic [15:0] key,
                                  input logic [31:0] runs, input logic [31:0] tick,
                                  input logic [TALLY_W-1:0] cnt, input logic is_last);
    rsp_t r;
    r.status     = status;
    r.due        = is_due;
    r.slot_index = slot;
    r.due_key    = key;
    r.runs_done  = runs;
    r.tick_now   = tick;
    r.live_tasks = live_count(cnt);
    r.last       = is_last;
    return r;
  endfunction

  // Shared period check, used once per scanned slot.
  ptd_due_unit u_due (
    .tick      (tick_counter),
    .prev_tick (view.prev_tick),
    .period    (view.period),
    .due       (due)
  );

  assign req_stall = (fsm != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign rd_idx    = idx;

  // Match conditions for the slot under the scan pointer.
  assign tick_hit = (view.state == ST_READY) && due && (dcnt < CNT_W'(MAX_OUT));
  assign add_hit  = (view.state == ST_EMPTY);
  assign rem_hit  = (view.state == ST_READY) && (view.key == key_q);
  assign last_idx = (idx == IDX_W'(SLOTS - 1));

  // A second due slot must wait until the held one can move to the output.
  assign tick_stall = (fsm == S_SCAN) && (op_q == OP_TICK) && tick_hit &&
                      pend_valid && !out_free;
  assign advance    = (fsm == S_SCAN) && !tick_stall;

  // The output register takes a held result when a further slot is due, since
  // it is not the last one, or the closing result when the request ends.
  assign rsp_load = (advance && (op_q == OP_TICK) && tick_hit && pend_valid) ||
                    ((fsm == S_DONE) && out_free);
  assign rsp_next = (fsm == S_DONE) ? final_rsp : pend;

  // Result for a dispatched slot; the run count shows after its increment.
  assign run_rsp = mk_rsp(STATUS_OK, 1'b1, slot_num(idx), view.key,
                          view.runs + 32'd1, tick_counter, tally, 1'b0);

  // Closing result of the request.
  always_comb begin
    case (op_q)
      OP_TICK: begin
        if (pend_valid) begin
          final_rsp      = pend;
          final_rsp.last = 1'b1;
        end else begin
          final_rsp = mk_rsp(STATUS_OK, 1'b0, 4'd0, 16'd0, 32'd0,
                             tick_counter, tally, 1'b1);
        end
      end
      OP_ADD: begin
        if (found) begin
          final_rsp = mk_rsp(STATUS_OK, 1'b0, slot_num(found_idx), 16'd0, 32'd0,
                             tick_counter, tally, 1'b1);
        end else begin
          final_rsp = mk_rsp(STATUS_FULL, 1'b0, 4'd0, 16'd0, 32'd0,
                             tick_counter, tally, 1'b1);
        end
      end
      OP_REMOVE: begin
        if (found) begin
          final_rsp = mk_rsp(STATUS_OK, 1'b0, slot_num(found_idx), 16'd0, 32'd0,
                             tick_counter, tally, 1'b1);
        end else begin
          final_rsp = mk_rsp(STATUS_NOKEY, 1'b0, 4'd0, 16'd0, 32'd0,
                             tick_counter, tally, 1'b1);
        end
      end
      default: begin
        final_rsp = mk_rsp(STATUS_OK, 1'b0, 4'd0, 16'd0, 32'd0,
                           tick_counter, tally, 1'b1);
      end
    endcase
  end

  // Table writes: free zombies when a tick arrives, then one slot per scan step.
  always_comb begin
    cmd.code   = TC_NONE;
    cmd.idx    = idx;
    cmd.key    = key_q;
    cmd.period = period_q;
    cmd.tick   = tick_counter;
    if (accept && (req.op == OP_TICK)) begin
      cmd.code = TC_FREE;
    end else if (advance) begin
      case (op_q)
        OP_TICK:   if (tick_hit) cmd.code = TC_RUN;
        OP_ADD:    if (add_hit)  cmd.code = TC_ADD;
        OP_REMOVE: if (rem_hit)  cmd.code = TC_KILL;
        default:   ;
      endcase
    end
  end

  // Sequencer, counters and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      fsm          <= S_IDLE;
      idx          <= '0;
      tick_counter <= 32'd0;
      tally        <= '0;
      dcnt         <= '0;
      found        <= 1'b0;
      pend_valid   <= 1'b0;
      rsp_valid    <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp       <= rsp_next;
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (fsm)
        S_IDLE: begin
          if (accept) begin
            op_q       <= req.op;
            key_q      <= req.task_key;
            period_q   <= req.run_period;
            idx        <= '0;
            dcnt       <= '0;
            found      <= 1'b0;
            pend_valid <= 1'b0;
            case (req.op)
              OP_TICK: begin
                tick_counter <= tick_counter + 32'd1;
                fsm          <= S_SCAN;
              end
              OP_ADD: begin
                fsm <= (tally >= TALLY_W'(SLOTS)) ? S_DONE : S_SCAN;
              end
              OP_REMOVE: fsm <= S_SCAN;
              default:   fsm <= S_DONE;
            endcase
          end
        end
        S_SCAN: begin
          if (advance) begin
            case (op_q)
              OP_TICK: begin
                if (tick_hit) begin
                  pend       <= run_rsp;
                  pend_valid <= 1'b1;
                  dcnt       <= dcnt + CNT_W'(1);
                end
                if (last_idx) begin
                  fsm <= S_DONE;
                end else begin
                  idx <= idx + IDX_W'(1);
                end
              end
              OP_ADD: begin
                if (add_hit) begin
                  found     <= 1'b1;
                  found_idx <= idx;
                  tally     <= tally + TALLY_W'(1);
                  fsm       <= S_DONE;
                end else if (last_idx) begin
                  fsm <= S_DONE;
                end else begin
                  idx <= idx + IDX_W'(1);
                end
              end
              OP_REMOVE: begin
                if (rem_hit) begin
                  found     <= 1'b1;
                  found_idx <= idx;
                  if (tally != '0) begin
                    tally <= tally - TALLY_W'(1);
                  end
                  fsm <= S_DONE;
                end else if (last_idx) begin
                  fsm <= S_DONE;
                end else begin
                  idx <= idx + IDX_W'(1);
                end
              end
              default: fsm <= S_DONE;
            endcase
          end
        end
        S_DONE: begin
          if (out_free) begin
            pend_valid <= 1'b0;
            fsm        <= S_IDLE;
          end
        end
        default: fsm <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/periodic_task_dispatcher_top.sv
`timescale 1ns / 1ps
// Periodic task dispatcher.
// Requests arrive on req (op, task_key, run_period) with req_valid/req_stall;
// results leave on rsp with rsp_valid/rsp_stall. A request is taken at a
// clock edge with valid high and stall low.
// Add fills the first empty slot, remove turns the first ready slot with a
// matching key into a zombie, and tick advances the tick counter, frees the
// zombies and dispatches every due ready slot in slot order, one result per
// dispatched slot, or a single empty result. The final result has last set.
// One request occupies the block from the accept cycle through a scan of the
// slots in order, one slot per step through the shared period compare unit,
// to the writing of the closing result. Add and remove stop at the matching
// slot; an add on a full table and an unused op skip the scan.
// req_stall is high for the whole request. A finished result waits in the
// output register while the next request is taken; a stalled output holds
// its result and the slot scan pauses when a further result is due.
// Reset empties every slot and clears the tick counter and the task count.
module periodic_task_dispatcher_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  ptd_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output ptd_pkg::rsp_t rsp
);
  import ptd_pkg::*;

  tbl_cmd_t         cmd;
  slot_view_t       view;
  logic [IDX_W-1:0] rd_idx;

  // Slot storage.
  ptd_slot_table u_table (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .rd_idx (rd_idx),
    .view   (view)
  );

  // Sequencer with the shared compare unit and the output register.
  ptd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cmd       (cmd),
    .rd_idx    (rd_idx),
    .view      (view)
  );

endmodule

// File: rtl/ptd_checker.sv
`timescale 1ns / 1ps
`include "periodic_task_dispatcher_top_assert.svh"

module ptd_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input ptd_pkg::rsp_t rsp
);
  import ptd_pkg::*;

  // A stalled result stays and keeps its contents.
  `PTD_CHECK_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

  // Every request keeps the block busy for at least the next cycle.
  `PTD_CHECK_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall)

  // The task count never exceeds the table size.
  `PTD_CHECK(a_live_bound, rsp_valid |-> (rsp.live_tasks <= 5'(LIVE_MAX)))

  // A failed add or remove is a lone closing result with no slot named.
  `PTD_CHECK(a_fail_single, (rsp_valid && (rsp.status != STATUS_OK)) |->
    (rsp.last && !rsp.due && (rsp.slot_index == 4'd0)))

endmodule

bind periodic_task_dispatcher_top ptd_checker u_ptd_checker (.*);

// File: dv/tb_periodic_task_dispatcher_top.sv
`timescale 1ns / 1ps

module tb_periodic_task_dispatcher_top;
  import ptd_pkg::*;

  // The fourth op code has no meaning and must leave the table alone.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_REQUESTS = 240;

  // One row of the request plan, with an optional hand-written result.
  typedef struct {
    req_t r;
    bit   fixed;
    rsp_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  // Shadow copy of the slot table.
  logic [1:0]  slot_st   [SLOTS];
  logic [15:0] slot_key  [SLOTS];
  logic [31:0] slot_per  [SLOTS];
  logic [31:0] slot_last [SLOTS];
  logic [31:0] slot_runs [SLOTS];
  logic [31:0] tick_ctr;
  int          tally;

  // Results of the latest request and the results still owed by the block.
  rsp_t step_out [MAX_OUT];
  int   step_n;
  rsp_t owed_rsp_q [$];

  plan_row_t req_plan [$];
  int        live_row = 0;
  int        next_row = 0;
  int        accepted_count = 0;
  int        rsp_count = 0;
  int        due_count = 0;
  int        full_count = 0;
  int        nokey_count = 0;
  int        fail_count = 0;
  int        cycle_count = 0;
  int        hold_left = 0;
  bit        hold_done = 1'b0;
  bit        calm;
  rsp_t      want;

  periodic_task_dispatcher_top DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #6 clk = ~clk;

  // A stretch of the random part runs with neither side idling.
  assign calm = (accepted_count >= 120) && (accepted_count < 180);

  // Result with the counter and task count as they stand now.
  function automatic rsp_t fill_rsp(input logic [1:0] status, input logic due,
                                    input int slot, input logic [15:0] key,
                                    input logic [31:0] runs);
    rsp_t o;
    o.status     = status;
    o.due        = due;
    o.slot_index = 4'(slot);
    o.due_key    = key;
    o.runs_done  = runs;
    o.tick_now   = tick_ctr;
    o.live_tasks = 5'((tally > 31) ? 31 : tally);
    o.last       = 1'b0;
    return o;
  endfunction

  // Hand-written closing result of a request that dispatches nothing.
  function automatic rsp_t mk_rsp(input logic [1:0] status, input int slot,
                                  input int tick, input int live);
    rsp_t o;
    o = '0;
    o.status     = status;
    o.slot_index = 4'(slot);
    o.tick_now   = 32'(tick);
    o.live_tasks = 5'(live);
    o.last       = 1'b1;
    return o;
  endfunction

  function automatic void add_row(input logic [1:0] op, input logic [15:0] key,
                                  input logic [31:0] period, input bit fixed,
                                  input rsp_t want_rsp);
    plan_row_t row;
    row.r.op         = op;
    row.r.task_key   = key;
    row.r.run_period = period;
    row.fixed        = fixed;
    row.want         = want_rsp;
    req_plan.push_back(row);
  endfunction

  // Updates the shadow table for one request and leaves its results in step_out.
  function automatic void predict_dispatch(input req_t r);
    int          hit;
    logic [31:0] gap;
    step_n = 0;
    hit = -1;
    case (r.op)
      OP_TICK: begin
        tick_ctr = tick_ctr + 32'd1;
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_st[i] == ST_ZOMBIE) begin
            slot_st[i] = ST_EMPTY;
          end
        end
        for (int i = 0; i < SLOTS && step_n < MAX_OUT; i++) begin
          gap = tick_ctr - slot_last[i];
          if (slot_st[i] == ST_READY && (slot_per[i] == 32'd0 || gap >= slot_per[i])) begin
            slot_last[i] = tick_ctr;
            slot_runs[i] = slot_runs[i] + 32'd1;
            step_out[step_n] = fill_rsp(STATUS_OK, 1'b1, i, slot_key[i], slot_runs[i]);
            step_n++;
          end
        end
        if (step_n == 0) begin
          step_out[0] = fill_rsp(STATUS_OK, 1'b0, 0, 16'd0, 32'd0);
          step_n = 1;
        end
      end
      OP_ADD: begin
        if (tally < SLOTS) begin
          for (int i = SLOTS - 1; i >= 0; i--) begin
            if (slot_st[i] == ST_EMPTY) begin
              hit = i;
            end
          end
        end
        if (hit < 0) begin
          step_out[0] = fill_rsp(STATUS_FULL, 1'b0, 0, 16'd0, 32'd0);
        end else begin
          slot_st[hit]   = ST_READY;
          slot_key[hit]  = r.task_key;
          slot_per[hit]  = r.run_period;
          slot_last[hit] = 32'd0;
          slot_runs[hit] = 32'd0;
          tally++;
          step_out[0] = fill_rsp(STATUS_OK, 1'b0, hit, 16'd0, 32'd0);
        end
        step_n = 1;
      end
      OP_REMOVE: begin
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (slot_st[i] == ST_READY && slot_key[i] == r.task_key) begin
            hit = i;
          end
        end
        if (hit < 0) begin
          step_out[0] = fill_rsp(STATUS_NOKEY, 1'b0, 0, 16'd0, 32'd0);
        end else begin
          slot_st[hit] = ST_ZOMBIE;
          if (tally > 0) begin
            tally--;
          end
          step_out[0] = fill_rsp(STATUS_OK, 1'b0, hit, 16'd0, 32'd0);
        end
        step_n = 1;
      end
      default: begin
        step_out[0] = fill_rsp(STATUS_OK, 1'b0, 0, 16'd0, 32'd0);
        step_n = 1;
      end
    endcase
    step_out[step_n - 1].last = 1'b1;
  endfunction

  // Directed table followed by random traffic in add-heavy and remove-heavy phases.
  function automatic void build_plan();
    int          key_pool [$];
    int          pick;
    int          roll;
    logic [1:0]  op;
    logic [15:0] key;
    logic [31:0] period;
    rsp_t        none;
    none = '0;

    // Empty table right after reset.
    add_row(OP_TICK, 16'h0000, 32'd0, 1, mk_rsp(STATUS_OK, 0, 1, 0));
    add_row(OP_REMOVE, 16'h0000, 32'd0, 1, mk_rsp(STATUS_NOKEY, 0, 1, 0));
    add_row(OP_UNUSED, 16'hFFFF, 32'hFFFFFFFF, 1, mk_rsp(STATUS_OK, 0, 1, 0));
    // Extreme keys and periods.
    add_row(OP_ADD, 16'hFFFF, 32'd0, 1, mk_rsp(STATUS_OK, 0, 1, 1));
    add_row(OP_ADD, 16'h0000, 32'hFFFFFFFF, 1, mk_rsp(STATUS_OK, 1, 1, 2));
    add_row(OP_ADD, 16'h1234, 32'd1, 1, mk_rsp(STATUS_OK, 2, 1, 3));
    add_row(OP_TICK, 16'h0000, 32'd0, 0, none);
    // A removed task turns into a zombie that cannot be removed again.
    add_row(OP_REMOVE, 16'hFFFF, 32'd0, 1, mk_rsp(STATUS_OK, 0, 2, 2));
    add_row(OP_REMOVE, 16'hFFFF, 32'd0, 1, mk_rsp(STATUS_NOKEY, 0, 2, 2));
    // The zombie keeps its slot until the next tick.
    add_row(OP_ADD, 16'h5555, 32'd3, 1, mk_rsp(STATUS_OK, 3, 2, 3));
    add_row(OP_TICK, 16'h0000, 32'd0, 0, none);
    // Fill the table with tasks that run every tick.
    for (int i = 0; i < 13; i++) begin
      add_row(OP_ADD, 16'hA000 | 16'(i), 32'd0, 1,
              mk_rsp(STATUS_OK, (i == 0) ? 0 : i + 3, 3, 4 + i));
    end
    add_row(OP_ADD, 16'hBEEF, 32'd7, 1, mk_rsp(STATUS_FULL, 0, 3, 16));
    // A free count but no empty slot still refuses the add.
    add_row(OP_REMOVE, 16'hA005, 32'd0, 1, mk_rsp(STATUS_OK, 8, 3, 15));
    add_row(OP_ADD, 16'hBEEF, 32'd7, 1, mk_rsp(STATUS_FULL, 0, 3, 15));
    add_row(OP_TICK, 16'h0000, 32'd0, 0, none);
    add_row(OP_TICK, 16'h0000, 32'd0, 0, none);

    key_pool = '{16'h0000, 16'h1234, 16'h5555};
    for (int i = 0; i < 13; i++) begin
      if (i != 5) begin
        key_pool.push_back(16'hA000 | i);
      end
    end

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      roll = $urandom_range(0, 99);
      if (((n / 45) % 2) == 0) begin
        op = (roll < 30) ? OP_TICK : (roll < 80) ? OP_ADD : (roll < 95) ? OP_REMOVE : OP_UNUSED;
      end else begin
        op = (roll < 35) ? OP_TICK : (roll < 55) ? OP_ADD : (roll < 95) ? OP_REMOVE : OP_UNUSED;
      end
      key = ($urandom_range(0, 99) < 60) ? 16'($urandom_range(0, 31))
                                         : 16'($urandom_range(0, 65535));
      case ($urandom_range(0, 9))
        0, 1:    period = 32'd0;
        7:       period = $urandom;
        8:       period = 32'hFFFFFFFF;
        9:       period = 32'($urandom_range(7, 40));
        default: period = 32'($urandom_range(1, 6));
      endcase
      if (op == OP_ADD) begin
        key_pool.push_back(key);
      end else if (op == OP_REMOVE && key_pool.size() > 0 && $urandom_range(0, 99) < 75) begin
        pick = $urandom_range(0, key_pool.size() - 1);
        key = 16'(key_pool[pick]);
        key_pool.delete(pick);
      end
      add_row(op, key, period, 0, none);
    end
  endfunction

  // Request side: take accepted requests into the shadow table, then offer the next one.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        predict_dispatch(req_plan[live_row].r);
        if (req_plan[live_row].fixed) begin
          owed_rsp_q.push_back(req_plan[live_row].want);
        end else begin
          for (int k = 0; k < step_n; k++) begin
            owed_rsp_q.push_back(step_out[k]);
          end
        end
        accepted_count = accepted_count + 1;
      end
      if (!req_valid || !req_stall) begin
        if (next_row < req_plan.size() && (calm || $urandom_range(0, 99) >= 11)) begin
          req       <= req_plan[next_row].r;
          live_row  <= next_row;
          next_row  <= next_row + 1;
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Result side stall: random idling, plus one long hold-off that backs up the requests.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (!hold_done && accepted_count >= 60) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      rsp_stall <= 1'b1;
    end else if (hold_left > 1) begin
      hold_left <= hold_left - 1;
      rsp_stall <= 1'b1;
    end else begin
      hold_left <= 0;
      rsp_stall <= !calm && ($urandom_range(0, 99) < 11);
    end
  end

  // Compare each accepted result with the oldest one owed.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      rsp_count++;
      if (rsp.due) begin
        due_count++;
      end
      if (rsp.status == STATUS_FULL) begin
        full_count++;
      end
      if (rsp.status == STATUS_NOKEY) begin
        nokey_count++;
      end
      if (owed_rsp_q.size() == 0) begin
        $error("unexpected result with no request outstanding: %p", rsp);
        fail_count++;
      end else begin
        want = owed_rsp_q.pop_front();
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp.status);
          fail_count++;
        end
        if (rsp.due !== want.due) begin
          $error("due: expected %0d, got %0d", want.due, rsp.due);
          fail_count++;
        end
        if (rsp.slot_index !== want.slot_index) begin
          $error("slot_index: expected %0d, got %0d", want.slot_index, rsp.slot_index);
          fail_count++;
        end
        if (rsp.due_key !== want.due_key) begin
          $error("due_key: expected %h, got %h", want.due_key, rsp.due_key);
          fail_count++;
        end
        if (rsp.runs_done !== want.runs_done) begin
          $error("runs_done: expected %0d, got %0d", want.runs_done, rsp.runs_done);
          fail_count++;
        end
        if (rsp.tick_now !== want.tick_now) begin
          $error("tick_now: expected %0d, got %0d", want.tick_now, rsp.tick_now);
          fail_count++;
        end
        if (rsp.live_tasks !== want.live_tasks) begin
          $error("live_tasks: expected %0d, got %0d", want.live_tasks, rsp.live_tasks);
          fail_count++;
        end
        if (rsp.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, rsp.last);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Reset, run the plan, drain and report.
  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_st[i]   = ST_EMPTY;
      slot_key[i]  = '0;
      slot_per[i]  = '0;
      slot_last[i] = '0;
      slot_runs[i] = '0;
    end
    tick_ctr = '0;
    tally = 0;
    build_plan();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    wait (accepted_count == req_plan.size());
    wait (owed_rsp_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d requests (ticks, adds, removes, unused op) and checked %0d results.",
             accepted_count, rsp_count);
    $display("Saw %0d task dispatches, %0d full-table refusals, %0d key misses.",
             due_count, full_count, nokey_count);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/ptd_pkg.sv
rtl/ptd_slot_table.sv
rtl/ptd_due_unit.sv
rtl/ptd_ctrl.sv
rtl/periodic_task_dispatcher_top.sv
rtl/ptd_checker.sv
dv/tb_periodic_task_dispatcher_top.sv
